>>> sv/spi_slave_buffered_byte_exchange_top_macros.svh
// Assertion macros for the SPI byte exchanger.
// Used by spi_slave_buffered_byte_exchange_top; expects a clock named clk and reset rst.
`ifndef SPI_SLAVE_BUFFERED_BYTE_EXCHANGE_TOP_MACROS_SVH
`define SPI_SLAVE_BUFFERED_BYTE_EXCHANGE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSBBE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSBBE_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ssbbe_pkg.sv
// Shared types for the SPI byte exchanger: event codes and ring control/status.
// No dependencies.
package ssbbe_pkg;

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_PUT      = 2'd1,
    OP_GET      = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_status_t;

endpackage

>>> sv/ssbbe_if.sv
// Channel interfaces for the SPI byte exchanger: event, result and filler write.
// Depends on ssbbe_pkg.
interface ssbbe_req_if;
  logic             valid;
  logic             ready;
  ssbbe_pkg::op_t   operation;
  logic [7:0]       data_in;
  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface ssbbe_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       ok;
  logic       rx_dropped;
  logic       tx_underrun;
  modport source (output valid, output data_out, output ok, output rx_dropped,
                  output tx_underrun, input ready);
  modport sink   (input valid, input data_out, input ok, input rx_dropped,
                  input tx_underrun, output ready);
endinterface

interface ssbbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ssbbe_ring.sv
// Byte ring with free-running counters modulo 2*DEPTH and a registered read port.
// Depends on ssbbe_pkg for the control and status structs.
module ssbbe_ring #(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ssbbe_pkg::ring_ctrl_t   ctrl,
  input  logic [7:0]              push_data,
  output ssbbe_pkg::ring_status_t status,
  output logic [7:0]              pop_data
);

  localparam int CW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = CW + 1;

  logic [7:0]    mem [DEPTH];
  logic [CW-1:0] wr_count;
  logic [CW-1:0] rd_count;
  logic [CW-1:0] wr_count_next;
  logic [CW-1:0] rd_count_next;
  logic [AW-1:0] wr_slot;
  logic [AW-1:0] rd_slot;
  logic [DW-1:0] fill;

  function automatic logic [CW-1:0] step(input logic [CW-1:0] c);
    return (c == CW'(2 * DEPTH - 1)) ? '0 : c + CW'(1);
  endfunction

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = (c >= CW'(DEPTH)) ? c - CW'(DEPTH) : c;
    return s[AW-1:0];
  endfunction

  always_comb begin
    wr_slot = slot(wr_count);
    rd_slot = slot(rd_count);
    fill = (wr_count >= rd_count) ? DW'(wr_count) - DW'(rd_count)
                                  : DW'(wr_count) + DW'(2 * DEPTH) - DW'(rd_count);
    status.full  = (fill == DW'(DEPTH));
    status.empty = (wr_count == rd_count);
    wr_count_next = ctrl.push ? step(wr_count) : wr_count;
    rd_count_next = ctrl.pop ? step(rd_count) : rd_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_count <= '0;
      rd_count <= '0;
    end else begin
      wr_count <= wr_count_next;
      rd_count <= rd_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_slot] <= push_data;
    end
  end

  // hold the read word until the next pop
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      pop_data <= mem[rd_slot];
    end
  end

endmodule

>>> sv/spi_slave_buffered_byte_exchange_top.sv
// SPI slave byte exchanger with receive and transmit rings.
// Depends on ssbbe_pkg, ssbbe_if, ssbbe_ring and the assertion macro header.
//
// Usage:
//   req carries one event per word: exchange (link byte in, byte out),
//   put (queue a transmit byte) or get (take a received byte).
//   rsp returns exactly one word per event: data_out, ok, rx_dropped,
//   tx_underrun. cfg writes the filler byte sent on transmit underrun;
//   write it only while no event is in flight.
// Pipeline: an accepted event updates the ring counters and reads the ring
//   memory into its read register while its kind and flags enter the middle
//   stage; the result register is loaded from that stage.
// Throughput: one event per cycle while rsp is not held, set by the single
//   memory access per ring per event and the counter update.
// Reset: all ring counters clear (both rings empty), the filler byte
//   returns to 0xFF, no result is pending. Ring memories are not cleared.
// Stall: while rsp is held, the result register and the middle stage hold;
//   req.ready drops once both are occupied, so no event is lost.
`include "spi_slave_buffered_byte_exchange_top_macros.svh"

module spi_slave_buffered_byte_exchange_top #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  ssbbe_req_if.sink   req,
  ssbbe_rsp_if.source rsp,
  ssbbe_cfg_if.sink   cfg
);

  ssbbe_pkg::ring_ctrl_t   rx_ctrl;
  ssbbe_pkg::ring_ctrl_t   tx_ctrl;
  ssbbe_pkg::ring_status_t rx_status;
  ssbbe_pkg::ring_status_t tx_status;
  logic [7:0]              rx_pop_data;
  logic [7:0]              tx_pop_data;

  logic [7:0] filler;

  // middle stage: event kind and flags, ring read data sits in the rings
  logic           mid_valid;
  ssbbe_pkg::op_t mid_op;
  logic           mid_ok;
  logic           mid_dropped;
  logic           mid_underrun;

  logic           accept;
  logic           advance;
  logic [7:0]     data_out_next;

  // result register advances when empty or being drained
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = !mid_valid || advance;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // decide ring moves from the current counters
  always_comb begin
    rx_ctrl = '0;
    tx_ctrl = '0;
    if (accept) begin
      unique case (req.operation)
        ssbbe_pkg::OP_EXCHANGE: begin
          rx_ctrl.push = !rx_status.full;
          tx_ctrl.pop  = !tx_status.empty;
        end
        ssbbe_pkg::OP_PUT: tx_ctrl.push = !tx_status.full;
        ssbbe_pkg::OP_GET: rx_ctrl.pop  = !rx_status.empty;
        default: ;
      endcase
    end
  end

  ssbbe_ring #(.DEPTH(DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rx_ctrl),
    .push_data (req.data_in),
    .status    (rx_status),
    .pop_data  (rx_pop_data)
  );

  ssbbe_ring #(.DEPTH(DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (tx_ctrl),
    .push_data (req.data_in),
    .status    (tx_status),
    .pop_data  (tx_pop_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filler <= 8'hFF;
    end else if (cfg.valid) begin
      filler <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (accept) begin
      mid_valid <= 1'b1;
    end else if (advance) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_op       <= req.operation;
      mid_dropped  <= (req.operation == ssbbe_pkg::OP_EXCHANGE) && rx_status.full;
      mid_underrun <= (req.operation == ssbbe_pkg::OP_EXCHANGE) && tx_status.empty;
      mid_ok       <= (req.operation == ssbbe_pkg::OP_EXCHANGE) ||
                      (req.operation == ssbbe_pkg::OP_PUT && !tx_status.full) ||
                      (req.operation == ssbbe_pkg::OP_GET && !rx_status.empty);
    end
  end

  // pick the outgoing byte: ring data, filler, or zero
  always_comb begin
    unique case (mid_op)
      ssbbe_pkg::OP_EXCHANGE: data_out_next = mid_underrun ? filler : tx_pop_data;
      ssbbe_pkg::OP_GET:      data_out_next = mid_ok ? rx_pop_data : 8'h00;
      default:                data_out_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mid_valid) begin
      rsp.data_out    <= data_out_next;
      rsp.ok          <= mid_ok;
      rsp.rx_dropped  <= mid_dropped;
      rsp.tx_underrun <= mid_underrun;
    end
  end

  `SSBBE_CHECK_RST(a_reset_empty, rst |=> !rsp.valid && !mid_valid, "pipeline not empty after reset")
  `SSBBE_CHECK(a_mid_held, mid_valid && !advance |=> mid_valid, "middle stage lost a word under stall")
  `SSBBE_CHECK(a_flags_need_ok, rsp.valid && (rsp.rx_dropped || rsp.tx_underrun) |-> rsp.ok, "exchange flag without ok")
  `SSBBE_CHECK(a_refused_zero, rsp.valid && !rsp.ok |-> rsp.data_out == 8'h00, "refused word carries data")

endmodule
